// ===== design/seam_energy_map_defines.svh =====
// Assertion macros shared by the checker of the seam energy map.
// Needs signals named clk and rst_n in the scope that uses them.
`ifndef SEAM_ENERGY_MAP_DEFINES_SVH
`define SEAM_ENERGY_MAP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SEM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SEM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sem_pkg.sv =====
// Shared widths, types and codes of the seam energy map.
// No dependencies; used by every module of the block.
`default_nettype none

package sem_pkg;

  localparam int MaxCols  = 256;
  localparam int MaxRows  = 256;
  localparam int ColW     = $clog2(MaxCols);
  localparam int RowW     = $clog2(MaxRows);
  localparam int DimW     = 9;
  localparam int EntryW   = 18;
  localparam int PixW     = 24;
  localparam int SumW     = 13;
  localparam int RatioW   = 11;
  localparam int ValW     = 8;
  localparam int InDataW  = 40;
  localparam int CfgIdxW  = 1;

  typedef logic [EntryW-1:0] entry_t;
  typedef logic [PixW-1:0]   pix_t;

  // Input beat kinds carried in in_tuser.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  localparam entry_t EntryMax = '1;

endpackage

`default_nettype wire

// ===== design/sem_norm_div.sv =====
// Iterative restoring divider that normalizes one map entry, one quotient bit a cycle.
// Depends on sem_pkg.
`default_nettype none

module sem_norm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  sem_pkg::entry_t              dividend,
  input  logic [sem_pkg::RatioW-1:0]   divisor,
  output logic                         done,
  output logic [sem_pkg::ValW-1:0]     quotient
);
  import sem_pkg::*;

  localparam int CntW = $clog2(ValW);

  logic              busy_r;
  logic              done_r;
  entry_t            rem_r;
  entry_t            dsh_r;
  logic [ValW-1:0]   quo_r;
  logic [CntW-1:0]   cnt_r;

  // Control: one step per cycle, a done pulse after the last quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(ValW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: compare with the shifted divisor and subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= EntryW'({divisor, {(ValW-1){1'b0}}});
      quo_r <= '0;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[ValW-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[ValW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/seam_energy_map.sv =====
// Top level of the seam energy map: pixel line store, cumulative map store,
// column sequencer and read path. Depends on sem_pkg and sem_norm_div.
//
// Use: pixels enter on the in_ stream as load beats (in_tuser = 0) in raster
// order; read beats (in_tuser = 1) ask for one normalized cumulative energy
// and give exactly one out_ beat. Load beats give no result beat.
// The beat that ends row r (r >= 1) starts the sequencer on cumulative
// row r-1: row 0 is written as zeros column by column; each column of a
// later row takes twelve single-port memory reads, each issued in ST_ISSUE
// and consumed in ST_USE, then a scale and a write step.
// The beat that ends the last row also runs the last row, after which reads
// return valid values.
// A read beat passes through a map read and the normalizing divider before
// its result goes to the output register; before the frame is complete it
// answers with status 1 and skips both. in_tready is low while the
// sequencer or a read runs; the block holds one item at a time.
// If the receiver stalls, the result stays in the output register and a
// finished read waits for it, holding in_tready low; until then loads flow.
// Reset (rst_n low, synchronous) restarts the frame and sets both
// dimensions to 256; the memories are not cleared. Configuration writes are
// always taken and also restart the frame.
`default_nettype none

module seam_energy_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // red [7:0], green [15:8], blue [23:16], read_row [31:24], read_col [39:32]
  input  logic [sem_pkg::InDataW-1:0]   in_tdata,
  // command [0]
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // energy_value [7:0]
  output logic [sem_pkg::ValW-1:0]      out_tdata,
  // status [0]
  output logic [0:0]                    out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sem_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sem_pkg::DimW-1:0]      cfg_data
);
  import sem_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ISSUE   = 4'd1;
  localparam logic [3:0] ST_USE     = 4'd2;
  localparam logic [3:0] ST_SCALE   = 4'd3;
  localparam logic [3:0] ST_ADD     = 4'd4;
  localparam logic [3:0] ST_ZERO    = 4'd5;
  localparam logic [3:0] ST_RDMAP   = 4'd6;
  localparam logic [3:0] ST_RDSTART = 4'd7;
  localparam logic [3:0] ST_RDWAIT  = 4'd8;
  localparam logic [3:0] ST_RES     = 4'd9;

  // Step numbers of one column: centre, eight neighbours, three entries above.
  localparam logic [3:0] STEP_CENTRE = 4'd0;
  localparam logic [3:0] STEP_UP     = 4'd9;
  localparam logic [3:0] STEP_LAST   = 4'd11;

  // Row and column offsets of a step.
  localparam logic [1:0] DR_UP   = 2'd0;
  localparam logic [1:0] DR_MID  = 2'd1;
  localparam logic [1:0] DR_DOWN = 2'd2;
  localparam logic [1:0] DC_LEFT = 2'd0;
  localparam logic [1:0] DC_SAME = 2'd1;
  localparam logic [1:0] DC_RGHT = 2'd2;

  localparam int SlotW = 2;
  localparam int PixAW = SlotW + ColW;
  localparam int MapAW = RowW + ColW;
  localparam int EnW   = 10;
  localparam int ProdW = SumW + 16;

  localparam logic [15:0] RecipThree = 16'd43691;
  localparam logic [15:0] RecipFive  = 16'd52429;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v, input int hi);
    logic [DimW-1:0] r;
    if (v < DimW'(2))       r = DimW'(2);
    else if (v > DimW'(hi)) r = DimW'(hi);
    else                    r = v;
    return r;
  endfunction

  function automatic logic [SlotW-1:0] inc3(input logic [SlotW-1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [SlotW-1:0] dec3(input logic [SlotW-1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [9:0] rgb_dist(input pix_t p, input pix_t q);
    logic [7:0] dr, dg, db;
    dr = (p[23:16] > q[23:16]) ? p[23:16] - q[23:16] : q[23:16] - p[23:16];
    dg = (p[15:8]  > q[15:8])  ? p[15:8]  - q[15:8]  : q[15:8]  - p[15:8];
    db = (p[7:0]   > q[7:0])   ? p[7:0]   - q[7:0]   : q[7:0]   - p[7:0];
    return {2'b00, dr} + {2'b00, dg} + {2'b00, db};
  endfunction

  logic [3:0]         state_r;
  logic [DimW-1:0]    width_r, height_r;
  logic [RowW-1:0]    load_row_r;
  logic [ColW-1:0]    load_col_r;
  logic [SlotW-1:0]   load_slot_r;
  logic               complete_r;
  entry_t             max_r;
  logic [RowW-1:0]    fin_row_r;
  logic [ColW-1:0]    fin_col_r;
  logic [SlotW-1:0]   fin_slot_r;
  logic               down_ok_r;
  logic               last_pend_r;
  logic [3:0]         st_r;
  pix_t               centre_r;
  logic [SumW-1:0]    sum_r;
  logic [3:0]         cnt_r;
  entry_t             best_r;
  logic [ProdW-1:0]   prod_r;
  logic [MapAW-1:0]   rd_addr_r;
  logic [ValW-1:0]    res_val_r;
  logic               res_stat_r;
  logic               out_valid_r;
  logic [ValW-1:0]    out_val_r;
  logic               out_stat_r;

  pix_t               pix_mem [0:3*MaxCols-1];
  entry_t             map_mem [0:MaxRows*MaxCols-1];
  pix_t               pix_q;
  entry_t             map_q;

  logic               in_acc, cfg_acc;
  logic               row_end, last_row, col_last;
  logic [1:0]         nb_dr, nb_dc;
  logic               nb_ok;
  logic [SlotW-1:0]   nb_slot;
  logic [ColW-1:0]    nb_col;
  logic [PixAW-1:0]   pix_raddr;
  logic [MapAW-1:0]   map_raddr;
  logic               map_we;
  entry_t             map_wdata;
  logic [EnW-1:0]     energy;
  logic [EntryW:0]    v_sum;
  entry_t             v_sat;
  logic [15:0]        recip;
  logic               div_start, div_done;
  logic [ValW-1:0]    div_quo;
  logic [RowW-1:0]    rd_row;
  logic [ColW-1:0]    rd_col;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign row_end  = ({1'b0, load_col_r} + 1'b1) >= width_r;
  assign last_row = ({1'b0, load_row_r} + 1'b1) >= height_r;
  assign col_last = ({1'b0, fin_col_r} + 1'b1) >= width_r;

  // Offsets of the current step.
  always_comb begin
    unique case (st_r)
      4'd1:    begin nb_dr = DR_UP;   nb_dc = DC_LEFT; end
      4'd2:    begin nb_dr = DR_UP;   nb_dc = DC_SAME; end
      4'd3:    begin nb_dr = DR_UP;   nb_dc = DC_RGHT; end
      4'd4:    begin nb_dr = DR_MID;  nb_dc = DC_LEFT; end
      4'd5:    begin nb_dr = DR_MID;  nb_dc = DC_RGHT; end
      4'd6:    begin nb_dr = DR_DOWN; nb_dc = DC_LEFT; end
      4'd7:    begin nb_dr = DR_DOWN; nb_dc = DC_SAME; end
      4'd8:    begin nb_dr = DR_DOWN; nb_dc = DC_RGHT; end
      4'd9:    begin nb_dr = DR_UP;   nb_dc = DC_SAME; end
      4'd10:   begin nb_dr = DR_UP;   nb_dc = DC_LEFT; end
      4'd11:   begin nb_dr = DR_UP;   nb_dc = DC_RGHT; end
      default: begin nb_dr = DR_MID;  nb_dc = DC_SAME; end
    endcase
  end

  // Neighbour position and whether it lies in the frame.
  always_comb begin
    case (nb_dr)
      DR_UP:   nb_slot = dec3(fin_slot_r);
      DR_DOWN: nb_slot = inc3(fin_slot_r);
      default: nb_slot = fin_slot_r;
    endcase
    case (nb_dc)
      DC_LEFT: nb_col = fin_col_r - 1'b1;
      DC_RGHT: nb_col = fin_col_r + 1'b1;
      default: nb_col = fin_col_r;
    endcase
    nb_ok = !((nb_dc == DC_LEFT) && (fin_col_r == '0)) &&
            !((nb_dc == DC_RGHT) && col_last) &&
            !((nb_dr == DR_DOWN) && !down_ok_r);
  end

  assign pix_raddr = {nb_slot, nb_col};
  assign map_raddr = (state_r == ST_RDMAP) ? rd_addr_r : {fin_row_r - 1'b1, nb_col};

  // Pixel line store: written by load beats, read by the sequencer.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_tuser[0] == CmdLoad) begin
      pix_mem[{load_slot_r, load_col_r}] <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
    end
    pix_q <= pix_mem[pix_raddr];
  end

  // Cumulative map store.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[{fin_row_r, fin_col_r}] <= map_wdata;
    end
    map_q <= map_mem[map_raddr];
  end

  // Division by the neighbour count as a reciprocal product.
  always_comb begin
    case (cnt_r)
      4'd8:    recip = 16'd1;
      4'd5:    recip = RecipFive;
      default: recip = RecipThree;
    endcase
    case (cnt_r)
      4'd8:    energy = prod_r[12:3];
      4'd5:    energy = prod_r[27:18];
      default: energy = prod_r[26:17];
    endcase
    v_sum = {1'b0, best_r} + (EntryW+1)'(energy);
    v_sat = v_sum[EntryW] ? EntryMax : v_sum[EntryW-1:0];
  end

  assign map_we    = (state_r == ST_ADD) || (state_r == ST_ZERO);
  assign map_wdata = (state_r == ST_ZERO) ? '0 : v_sat;

  // Read position, saturated to the frame in use.
  assign rd_row = ({1'b0, in_tdata[31:24]} >= height_r) ? RowW'(height_r - 1'b1)
                                                       : in_tdata[31:24];
  assign rd_col = ({1'b0, in_tdata[39:32]} >= width_r) ? ColW'(width_r - 1'b1)
                                                      : in_tdata[39:32];

  assign div_start = (state_r == ST_RDSTART);

  sem_norm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (map_q),
    .divisor  (RatioW'(max_r[EntryW-1:8]) + 1'b1),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer and frame bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= DimW'(MaxCols);
      height_r    <= DimW'(MaxRows);
      load_row_r  <= '0;
      load_col_r  <= '0;
      load_slot_r <= '0;
      complete_r  <= 1'b0;
      max_r       <= '0;
      last_pend_r <= 1'b0;
      down_ok_r   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        if (cfg_index == RegWidth) width_r  <= clamp_dim(cfg_data, MaxCols);
        else                       height_r <= clamp_dim(cfg_data, MaxRows);
        load_row_r  <= '0;
        load_col_r  <= '0;
        load_slot_r <= '0;
        complete_r  <= 1'b0;
        max_r       <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_tuser[0] == CmdLoad) begin
            if (complete_r) begin
              complete_r <= 1'b0;
              max_r      <= '0;
            end
            if (!row_end) begin
              load_col_r <= load_col_r + 1'b1;
            end else begin
              load_col_r <= '0;
              if (last_row) begin
                load_row_r  <= '0;
                load_slot_r <= '0;
              end else begin
                load_row_r  <= load_row_r + 1'b1;
                load_slot_r <= inc3(load_slot_r);
              end
              if (load_row_r != '0) begin
                fin_row_r   <= load_row_r - 1'b1;
                fin_slot_r  <= dec3(load_slot_r);
                fin_col_r   <= '0;
                down_ok_r   <= 1'b1;
                last_pend_r <= last_row;
                st_r        <= STEP_CENTRE;
                state_r     <= (load_row_r == RowW'(1)) ? ST_ZERO : ST_ISSUE;
              end
            end
          end else if (in_acc) begin
            if (!complete_r) begin
              res_val_r  <= '0;
              res_stat_r <= 1'b1;
              state_r    <= ST_RES;
            end else begin
              rd_addr_r <= {rd_row, rd_col};
              state_r   <= ST_RDMAP;
            end
          end
        end
        ST_ISSUE: state_r <= ST_USE;
        ST_USE: begin
          if (st_r == STEP_CENTRE) begin
            centre_r <= pix_q;
            sum_r    <= '0;
            cnt_r    <= '0;
          end else if (st_r < STEP_UP) begin
            if (nb_ok) begin
              sum_r <= sum_r + SumW'(rgb_dist(centre_r, pix_q));
              cnt_r <= cnt_r + 1'b1;
            end
          end else if (st_r == STEP_UP) begin
            best_r <= map_q;
          end else if (nb_ok && map_q < best_r) begin
            best_r <= map_q;
          end
          if (st_r == STEP_LAST) begin
            state_r <= ST_SCALE;
          end else begin
            st_r    <= st_r + 1'b1;
            state_r <= ST_ISSUE;
          end
        end
        ST_SCALE: begin
          prod_r  <= sum_r * recip;
          state_r <= ST_ADD;
        end
        ST_ADD, ST_ZERO: begin
          if (state_r == ST_ADD && v_sat > max_r) max_r <= v_sat;
          st_r <= STEP_CENTRE;
          if (!col_last) begin
            fin_col_r <= fin_col_r + 1'b1;
            state_r   <= (state_r == ST_ZERO) ? ST_ZERO : ST_ISSUE;
          end else if (last_pend_r) begin
            // The last row follows, with no row below it.
            last_pend_r <= 1'b0;
            fin_row_r   <= fin_row_r + 1'b1;
            fin_slot_r  <= inc3(fin_slot_r);
            fin_col_r   <= '0;
            down_ok_r   <= 1'b0;
            state_r     <= ST_ISSUE;
          end else begin
            if (!down_ok_r) complete_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        ST_RDMAP:   state_r <= ST_RDSTART;
        ST_RDSTART: state_r <= ST_RDWAIT;
        ST_RDWAIT: begin
          if (div_done) begin
            res_val_r  <= div_quo;
            res_stat_r <= 1'b0;
            state_r    <= ST_RES;
          end
        end
        ST_RES: begin
          if (!out_valid_r || out_tready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RES && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
      out_val_r   <= res_val_r;
      out_stat_r  <= res_stat_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_stat_r;

endmodule

`default_nettype wire

// ===== design/sem_checker.sv =====
// Port-level checker of the seam energy map, bound to the top level.
// Depends on sem_pkg and seam_energy_map_defines.svh.
`default_nettype none
`include "seam_energy_map_defines.svh"

module sem_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [0:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [sem_pkg::ValW-1:0]    out_tdata,
  input logic [0:0]                  out_tuser
);
  import sem_pkg::*;

  // A stalled result beat holds its payload.
  `SEM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat dropped or changed while stalled")

  // A not-ready answer carries a zero value.
  `SEM_ASSERT_IMP(a_status_zero, out_tvalid && out_tuser[0], out_tdata == '0, "not-ready result with nonzero value")

  // A read keeps the block busy in the following cycle.
  `SEM_ASSERT_NXT(a_read_busy, in_tvalid && in_tready && in_tuser[0] == CmdRead, !in_tready, "input taken during a read")

  // A load never produces a result beat.
  `SEM_ASSERT_NXT(a_load_silent, in_tvalid && in_tready && in_tuser[0] == CmdLoad && !out_tvalid, !out_tvalid, "result beat after a load")

endmodule

bind seam_energy_map sem_checker u_sem_checker (.*);

`default_nettype wire

// ===== tb/seam_energy_map_checker.sv =====
// Checker for the seam energy map: watches the config, pixel and result channels,
// keeps its own copy of the energy map and compares every result beat.
// Depends on sem_pkg for widths, beat kinds and register indexes.
`default_nettype none

module seam_energy_map_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [sem_pkg::InDataW-1:0] in_tdata,
  input  logic [0:0]                  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [sem_pkg::ValW-1:0]    out_tdata,
  input  logic [0:0]                  out_tuser,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [sem_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sem_pkg::DimW-1:0]    cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import sem_pkg::*;

  typedef struct packed {
    logic [ValW-1:0] energy;
    logic            not_ready;
  } energy_read_t;

  pix_t         line_store [3*MaxCols];
  entry_t       energy_map [MaxRows*MaxCols];
  entry_t       frame_peak;
  int unsigned  fill_row, fill_col;
  logic         map_ready;
  logic [DimW-1:0] width_reg, height_reg;
  energy_read_t reads_due [$];

  function automatic int unsigned used_dim(logic [DimW-1:0] v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned color_gap(pix_t p, pix_t q);
    return chan_gap(p[23:16], q[23:16]) + chan_gap(p[15:8], q[15:8])
         + chan_gap(p[7:0], q[7:0]);
  endfunction

  function automatic int unsigned local_energy(int r, int c, int w, int h);
    int unsigned sum, cnt;
    pix_t mid;
    sum = 0;
    cnt = 0;
    mid = line_store[(r % 3) * MaxCols + c];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 && r + dr < h
            && c + dc < w) begin
          sum += color_gap(mid, line_store[((r + dr) % 3) * MaxCols + c + dc]);
          cnt++;
        end
      end
    end
    return sum / cnt;
  endfunction

  // Build one cumulative row from the row above and track the frame peak.
  task automatic build_row(int r, int w, int h);
    int unsigned best, v;
    for (int c = 0; c < w; c++) begin
      v = 0;
      if (r > 0) begin
        best = energy_map[(r - 1) * MaxCols + c];
        if (c > 0 && energy_map[(r - 1) * MaxCols + c - 1] < best)
          best = energy_map[(r - 1) * MaxCols + c - 1];
        if (c + 1 < w && energy_map[(r - 1) * MaxCols + c + 1] < best)
          best = energy_map[(r - 1) * MaxCols + c + 1];
        v = local_energy(r, c, w, h) + best;
        if (v > EntryMax) v = EntryMax;
      end
      energy_map[r * MaxCols + c] = entry_t'(v);
      if (v > frame_peak) frame_peak = entry_t'(v);
    end
  endtask

  // Sample every channel at the clock edge, before the block updates.
  always @(posedge clk) begin
    int unsigned w, h, r, c;
    energy_read_t want, got;
    if (!rst_n) begin
      width_reg  = DimW'(MaxCols);
      height_reg = DimW'(MaxRows);
      frame_peak = 0;
      fill_row   = 0;
      fill_col   = 0;
      map_ready  = 0;
      reads_due.delete();
      fail_count = 0;
    end else begin
      w = used_dim(width_reg, MaxCols);
      h = used_dim(height_reg, MaxRows);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegWidth) width_reg = cfg_data;
        else height_reg = cfg_data;
        frame_peak = 0;
        fill_row   = 0;
        fill_col   = 0;
        map_ready  = 0;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CmdLoad) begin
          if (map_ready) begin
            frame_peak = 0;
            fill_row   = 0;
            fill_col   = 0;
            map_ready  = 0;
          end
          line_store[(fill_row % 3) * MaxCols + fill_col] =
            {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
          if (fill_col + 1 >= w) begin
            fill_col = 0;
            if (fill_row >= 1) build_row(fill_row - 1, w, h);
            if (fill_row + 1 >= h) begin
              build_row(fill_row, w, h);
              map_ready = 1;
              fill_row  = 0;
            end else begin
              fill_row++;
            end
          end else begin
            fill_col++;
          end
        end else if (!map_ready) begin
          reads_due.push_back('{energy: '0, not_ready: 1'b1});
        end else begin
          r = in_tdata[31:24];
          c = in_tdata[39:32];
          if (r >= h) r = h - 1;
          if (c >= w) c = w - 1;
          want.energy    = ValW'(energy_map[r * MaxCols + c] / (frame_peak / 256 + 1));
          want.not_ready = 1'b0;
          reads_due.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{energy: out_tdata, not_ready: out_tuser[0]};
        if (reads_due.size() == 0) begin
          $display("%0t: unexpected result beat energy=%0d status=%0d", $time,
                   got.energy, got.not_ready);
          fail_count++;
        end else begin
          want = reads_due.pop_front();
          if (got.energy !== want.energy) begin
            $display("%0t: energy mismatch expected %0d actual %0d", $time,
                     want.energy, got.energy);
            fail_count++;
          end
          if (got.not_ready !== want.not_ready) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time,
                     want.not_ready, got.not_ready);
            fail_count++;
          end
        end
      end
    end
    pending = reads_due.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_seam_energy_map.sv =====
// Testbench top for the seam energy map: clock, reset, pixel and read stimulus,
// config writes and the verdict. Depends on sem_pkg, seam_energy_map and the checker.
`default_nettype none

module tb_seam_energy_map;
  import sem_pkg::*;

  logic                 clk, rst_n;
  logic                 in_tvalid, in_tready;
  logic [InDataW-1:0]   in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid, out_tready;
  logic [ValW-1:0]      out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [DimW-1:0]      cfg_data;
  int                   fail_count, pending;
  int                   beats_sent, cycle_count, cur_w, cur_h;
  logic                 calm_in, calm_out, hold_req;

  seam_energy_map DUT (.*);

  seam_energy_map_checker energy_check (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int gap;
    out_tready <= 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 0;
        repeat (500) @(posedge clk);
      end
      gap = calm_out ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_beat(logic kind, logic [InDataW-1:0] data);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= data;
    in_tvalid <= 1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    beats_sent++;
  endtask

  task automatic load_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    send_beat(CmdLoad, {16'($urandom_range(0, 65535)), blue, green, red});
  endtask

  task automatic read_energy(logic [7:0] row, logic [7:0] col);
    send_beat(CmdRead, {col, row, 24'($urandom)});
  endtask

  function automatic int clamp_dim(int v);
    return (v < 2) ? 2 : (v > 256) ? 256 : v;
  endfunction

  // Drain, let the row sequencer finish, then write both dimensions.
  task automatic set_frame(logic [DimW-1:0] w, logic [DimW-1:0] h);
    in_tvalid <= 0;
    wait (pending == 0);
    repeat (60 * cur_w + 200) @(posedge clk);
    cfg_index <= RegWidth;
    cfg_data  <= w;
    cfg_valid <= 1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= RegHeight;
    cfg_data  <= h;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
    cur_w = clamp_dim(w);
    cur_h = clamp_dim(h);
  endtask

  // One frame of random pixels, with occasional early reads or an abort.
  task automatic load_frame(bit may_abort);
    int stop;
    logic [23:0] p;
    stop = (may_abort && $urandom_range(0, 9) == 0) ?
           $urandom_range(0, cur_w * cur_h - 1) : cur_w * cur_h;
    for (int i = 0; i < stop; i++) begin
      p = 24'($urandom);
      case ($urandom_range(0, 9))
        0: p = '0;
        1: p = '1;
        default: ;
      endcase
      load_pixel(p[7:0], p[15:8], p[23:16]);
      if ($urandom_range(0, 11) == 0) read_energy(8'($urandom), 8'($urandom));
    end
  endtask

  task automatic read_some(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) read_energy(8'($urandom), 8'($urandom));
      else read_energy(8'($urandom_range(0, cur_h - 1)),
                       8'($urandom_range(0, cur_w - 1)));
    end
  endtask

  initial begin
    int frame_no;
    rst_n = 0;
    in_tvalid <= 0;
    in_tdata  <= '0;
    in_tuser  <= CmdLoad;
    cfg_valid <= 0;
    cfg_index <= RegWidth;
    cfg_data  <= '0;
    calm_in = 0;
    calm_out = 0;
    hold_req = 0;
    beats_sent = 0;
    cur_w = 256;
    cur_h = 256;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: read before any frame, dimensions below range, extreme pixels.
    read_energy(8'hFF, 8'hFF);
    set_frame(0, 1);
    load_pixel(8'h00, 8'h00, 8'h00);
    load_pixel(8'hFF, 8'hFF, 8'hFF);
    read_energy(8'h00, 8'h00);
    load_pixel(8'hFF, 8'h00, 8'hFF);
    load_pixel(8'h00, 8'hFF, 8'h00);
    read_energy(8'h00, 8'h00);
    read_energy(8'h01, 8'h01);
    read_energy(8'hFF, 8'hFF);
    read_energy(8'h00, 8'hFF);
    // A load after completion starts a fresh frame.
    load_pixel(8'hFF, 8'hFF, 8'h00);
    read_energy(8'h01, 8'h00);
    load_pixel(8'h00, 8'h00, 8'hFF);
    load_pixel(8'h12, 8'hED, 8'h80);
    load_pixel(8'hFF, 8'h7F, 8'h01);
    read_energy(8'h01, 8'h00);
    set_frame(3, 4);
    load_frame(0);
    read_some(4);

    // Random frames; a few at the largest sizes.
    frame_no = 0;
    while (beats_sent < 1900) begin
      frame_no++;
      calm_in  = ($urandom_range(0, 5) == 0);
      calm_out = ($urandom_range(0, 5) == 0);
      if (frame_no == 4) set_frame(511, 2);
      else if (frame_no == 9) set_frame(2, 300);
      else if ($urandom_range(0, 3) != 0)
        set_frame(DimW'($urandom_range(0, 9)), DimW'($urandom_range(0, 9)));
      load_frame(1);
      if (frame_no == 2) begin
        // Long receiver hold-off while reads keep coming.
        calm_in = 1;
        hold_req = 1;
        read_some(12);
        calm_in = 0;
      end
      read_some($urandom_range(3, 10));
    end

    in_tvalid <= 0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
